### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Check a consequence in the cycle after its trigger, outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/ldpm_pkg.sv
// Shared constants, register codes and width helpers of the lens distortion point map.
package ldpm_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 22;
  localparam int unsigned COEF_WIDTH_DEF  = 32;
  localparam int unsigned COEF_INT_BITS   = 4;
  localparam int unsigned INV_WIDTH       = 32;

  // r2 shift is R2_SHIFT_REF - frac; tangential shifts are frac + TAN_DXY_SHIFT
  // for the dx*dy and d^2 parts and 2*frac - TAN_R2_SHIFT for the r2 parts
  localparam int unsigned R2_SHIFT_REF  = 48;
  localparam int unsigned TAN_DXY_SHIFT = 7;
  localparam int unsigned TAN_R2_SHIFT  = 8;

  // intermediates saturate to +-2^LIM_EXP
  localparam int unsigned LIM_EXP = 60;
  localparam int unsigned VAL_W   = LIM_EXP + 2;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned SAT_W   = 128;

  localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-LIM_EXP-1){1'b0}}, 1'b1,
                                               {LIM_EXP{1'b0}}};
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI;

  // register stages from input acceptance to the last result stage
  localparam int unsigned PIPE_STAGES = 24;

  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_K1  = 3'd0;
  localparam cfg_idx_t REG_K2  = 3'd1;
  localparam cfg_idx_t REG_K3  = 3'd2;
  localparam cfg_idx_t REG_P1  = 3'd3;
  localparam cfg_idx_t REG_P2  = 3'd4;
  localparam cfg_idx_t REG_CX  = 3'd5;
  localparam cfg_idx_t REG_CY  = 3'd6;
  localparam cfg_idx_t REG_INV = 3'd7;

  // width of floor(a*b / 2^sh) once saturated to +-2^LIM_EXP
  function automatic int mul_ow(input int aw, input int bw, input int sh);
    int qw;
    qw = aw + bw - sh;
    return (qw <= int'(VAL_W) - 1) ? qw : int'(VAL_W);
  endfunction

  // width of a sum once saturated to +-2^LIM_EXP
  function automatic int clip_w(input int w);
    return (w < int'(VAL_W)) ? w : int'(VAL_W);
  endfunction

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat60(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      return VAL_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return VAL_W'(SAT_LO);
    end
    return VAL_W'(v);
  endfunction

endpackage

### rtl/core/ldpm_point_if.sv
// Input channel: one point per beat with valid/ready handshake.
interface ldpm_point_if #(
  parameter int unsigned COORD_WIDTH = ldpm_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

### rtl/core/ldpm_mapped_if.sv
// Output channel: one distorted point per beat with valid/ready handshake.
interface ldpm_mapped_if #(
  parameter int unsigned COORD_WIDTH = ldpm_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] mapped_x;
  logic signed [COORD_WIDTH-1:0] mapped_y;

  modport source (output valid, output mapped_x, output mapped_y, input ready);
  modport sink   (input valid, input mapped_x, input mapped_y, output ready);
endinterface

### rtl/core/ldpm_delay.sv
// Enabled shift line that carries a value alongside the pipeline.
module ldpm_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < int'(DEPTH); i++) begin
        stage_q[i] <= stage_q[i-1];
      end
    end
  end

  assign q_o = stage_q[DEPTH-1];

endmodule

### rtl/core/ldpm_mul.sv
// Three-stage signed multiplier: split partial products, combine, floor shift and saturate.
module ldpm_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32,
  parameter int unsigned SH = 0
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  logic signed [AW-1:0]                          a_i,
  input  logic signed [BW-1:0]                          b_i,
  output logic signed [ldpm_pkg::mul_ow(AW, BW, SH)-1:0] p_o
);

  localparam int unsigned OW   = ldpm_pkg::mul_ow(AW, BW, SH);
  localparam int unsigned HA   = AW / 2;
  localparam int unsigned HB   = BW / 2;
  localparam int unsigned PW   = AW + BW;
  localparam int unsigned LLW  = HA + HB;
  localparam int unsigned LHW  = HA + 1 + BW - HB;
  localparam int unsigned HLW  = AW - HA + HB + 1;
  localparam int unsigned HHW  = AW - HA + BW - HB;
  localparam int unsigned SATW = ldpm_pkg::SAT_W;

  logic        [HA-1:0]    a_lo;
  logic        [HB-1:0]    b_lo;
  logic signed [HA:0]      a_lo_s;
  logic signed [HB:0]      b_lo_s;
  logic signed [AW-HA-1:0] a_hi;
  logic signed [BW-HB-1:0] b_hi;

  logic        [LLW-1:0] pp_ll_d, pp_ll_q;
  logic signed [LHW-1:0] pp_lh_d, pp_lh_q;
  logic signed [HLW-1:0] pp_hl_d, pp_hl_q;
  logic signed [HHW-1:0] pp_hh_d, pp_hh_q;
  logic signed [PW-1:0]  prod_d, prod_q;
  logic signed [OW-1:0]  p_d, p_q;

  assign a_lo   = a_i[HA-1:0];
  assign b_lo   = b_i[HB-1:0];
  assign a_lo_s = $signed({1'b0, a_lo});
  assign b_lo_s = $signed({1'b0, b_lo});
  assign a_hi   = $signed(a_i[AW-1:HA]);
  assign b_hi   = $signed(b_i[BW-1:HB]);

  assign pp_ll_d = LLW'(a_lo) * LLW'(b_lo);
  assign pp_lh_d = a_lo_s * b_hi;
  assign pp_hl_d = a_hi * b_lo_s;
  assign pp_hh_d = a_hi * b_hi;

  // a_lo*b_hi sits at the weight of b's split, a_hi*b_lo at that of a's
  assign prod_d = (PW'(pp_hh_q) << (HA + HB)) + (PW'(pp_lh_q) << HB)
                + (PW'(pp_hl_q) << HA) + PW'(pp_ll_q);

  // arithmetic shift gives the floor of the exact product
  assign p_d = OW'(ldpm_pkg::sat60(SATW'(prod_q >>> SH)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= pp_ll_d;
      pp_lh_q <= pp_lh_d;
      pp_hl_q <= pp_hl_d;
      pp_hh_q <= pp_hh_d;
      prod_q  <= prod_d;
      p_q     <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/lens_distortion_point_map.sv
// Top level of the lens distortion point map: configuration registers and point pipeline.
//
// Maps one point per clock through a radial plus tangential lens model: offsets
// dx, dy from the configured centre give a normalised r^2 (via the software-supplied
// reciprocal of the squared corner distance), the radial scale 1 + k1 r^2 + k2 r^4
// + k3 r^6 multiplies the offsets, the tangential terms are added and the result
// saturates to the coordinate range. A new point is taken every cycle while the
// output side keeps up; between acceptance and output a point's result passes
// through 24 pipeline stages and the output register, set by the chain of
// multipliers r^2 -> r^4 -> r^6 -> coefficient products -> scale -> scaled
// offsets. All wide products are split into partial products of at most
// 32x32 bits. When the output is stalled the pipeline keeps taking points until
// its last stage is occupied, so a waiting result does not block input on its own.
// Write the configuration registers only while no point is in flight.
module lens_distortion_point_map #(
  parameter int unsigned COORD_WIDTH = ldpm_pkg::COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = ldpm_pkg::COEF_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  ldpm_pkg::cfg_idx_t                     cfg_idx_i,
  input  logic [ldpm_pkg::max3(COEF_WIDTH, COORD_WIDTH,
                               ldpm_pkg::INV_WIDTH)-1:0] cfg_data_i,
  ldpm_point_if.sink                             point_i,
  ldpm_mapped_if.source                          mapped_o
);

  // Widths follow the value ranges through the datapath
  localparam int unsigned FRAC   = COEF_WIDTH - ldpm_pkg::COEF_INT_BITS;
  localparam int unsigned DW     = COORD_WIDTH + 1;
  localparam int unsigned INVSW  = ldpm_pkg::INV_WIDTH + 1;
  localparam int unsigned VALW   = ldpm_pkg::VAL_W;
  localparam int unsigned ACCW   = ldpm_pkg::ACC_W;
  localparam int unsigned SATW   = ldpm_pkg::SAT_W;
  localparam int unsigned NSTAGE = ldpm_pkg::PIPE_STAGES;

  localparam int unsigned SH_R2  = ldpm_pkg::R2_SHIFT_REF - FRAC;
  localparam int unsigned SH_DXY = FRAC + ldpm_pkg::TAN_DXY_SHIFT;
  localparam int unsigned SH_TR2 = 2 * FRAC - ldpm_pkg::TAN_R2_SHIFT;

  localparam int unsigned SQW  = ldpm_pkg::mul_ow(DW, DW, 0);
  localparam int unsigned SUMW = ldpm_pkg::clip_w(SQW + 1);
  localparam int unsigned R2W  = ldpm_pkg::mul_ow(SUMW, INVSW, SH_R2);
  localparam int unsigned R4W  = ldpm_pkg::mul_ow(R2W, R2W, FRAC);
  localparam int unsigned R6W  = ldpm_pkg::mul_ow(R4W, R2W, FRAC);
  localparam int unsigned T1W  = ldpm_pkg::mul_ow(COEF_WIDTH, R2W, FRAC);
  localparam int unsigned T2W  = ldpm_pkg::mul_ow(COEF_WIDTH, R4W, FRAC);
  localparam int unsigned T3W  = ldpm_pkg::mul_ow(COEF_WIDTH, R6W, FRAC);
  localparam int unsigned XRW  = ldpm_pkg::mul_ow(VALW, DW, FRAC);
  localparam int unsigned TDW  = ldpm_pkg::mul_ow(COEF_WIDTH, SQW, SH_DXY);
  localparam int unsigned TRW  = ldpm_pkg::mul_ow(COEF_WIDTH, R2W, SH_TR2);

  localparam logic signed [ACCW-1:0] SCALE_ONE = ACCW'(1) << FRAC;
  localparam logic signed [ACCW-1:0] CO_MAX    = (ACCW'(1) << (COORD_WIDTH - 1)) - ACCW'(1);
  localparam logic signed [ACCW-1:0] CO_MIN    = -CO_MAX - ACCW'(1);

  // Configuration registers
  logic signed [COEF_WIDTH-1:0]         k1_q, k2_q, k3_q, p1_q, p2_q;
  logic signed [COORD_WIDTH-1:0]        cx_q, cy_q;
  logic        [ldpm_pkg::INV_WIDTH-1:0] inv_q;
  logic signed [INVSW-1:0]              inv_s;

  // Pipeline control
  logic              adv;
  logic [NSTAGE-1:0] v_q;
  logic              out_load;
  logic              out_valid_d, out_valid_q;

  // Datapath, named by the stage at which each value is registered
  logic signed [DW-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic signed [SQW-1:0]  dxsq, dysq, dxdy;
  logic signed [SQW-1:0]  dxsq_s8, dysq_s8, dxdy_s8;
  logic signed [SUMW-1:0] sum_d, sum_q;
  logic signed [R2W-1:0]  r2, r2_s11, r2_s14;
  logic signed [R4W-1:0]  r4, r4_s14;
  logic signed [R6W-1:0]  r6;
  logic signed [T1W-1:0]  t1;
  logic signed [T2W-1:0]  t2;
  logic signed [T3W-1:0]  t3;
  logic signed [ACCW-1:0] sa_d, sa_q, sb_d, sb_q;
  logic signed [VALW-1:0] scale_d, scale_q;
  logic signed [DW-1:0]   dx_s19, dy_s19;
  logic signed [XRW-1:0]  xr, yr;
  logic signed [TDW-1:0]  ta1, ta3, tb2, tb3;
  logic signed [TRW-1:0]  ta2, tb1;
  logic signed [ACCW-1:0] txa_d, txa_q, tya_d, tya_q;
  logic signed [TDW-1:0]  ta3_q, tb3_q;
  logic signed [VALW-1:0] tx_d, tx_q, ty_d, ty_q, tx_s22, ty_s22;
  logic signed [ACCW-1:0] xs_d, xs_q, ys_d, ys_q;
  logic signed [COORD_WIDTH-1:0] mx_d, mx_q, my_d, my_q;
  logic signed [COORD_WIDTH-1:0] mapped_x_q, mapped_y_q;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [ACCW-1:0] v
  );
    if (v > CO_MAX) begin
      return COORD_WIDTH'(CO_MAX);
    end else if (v < CO_MIN) begin
      return COORD_WIDTH'(CO_MIN);
    end
    return COORD_WIDTH'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: plain register writes, indexes outside the list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q  <= '0;
      k2_q  <= '0;
      k3_q  <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
      inv_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ldpm_pkg::REG_K1:  k1_q  <= cfg_data_i[COEF_WIDTH-1:0];
        ldpm_pkg::REG_K2:  k2_q  <= cfg_data_i[COEF_WIDTH-1:0];
        ldpm_pkg::REG_K3:  k3_q  <= cfg_data_i[COEF_WIDTH-1:0];
        ldpm_pkg::REG_P1:  p1_q  <= cfg_data_i[COEF_WIDTH-1:0];
        ldpm_pkg::REG_P2:  p2_q  <= cfg_data_i[COEF_WIDTH-1:0];
        ldpm_pkg::REG_CX:  cx_q  <= cfg_data_i[COORD_WIDTH-1:0];
        ldpm_pkg::REG_CY:  cy_q  <= cfg_data_i[COORD_WIDTH-1:0];
        ldpm_pkg::REG_INV: inv_q <= cfg_data_i[ldpm_pkg::INV_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // unsigned reciprocal enters the signed multiplier with a zero sign bit
  assign inv_s = $signed({1'b0, inv_q});

  // ---------------------------------------------------------------------------
  // Flow control: advance the whole pipeline unless the last stage holds a
  // result that cannot move into the output register. Bubbles ahead of the
  // last stage keep filling while the output waits.
  // ---------------------------------------------------------------------------
  assign adv           = ~v_q[NSTAGE-1] | ~out_valid_q | mapped_o.ready;
  assign point_i.ready = adv;
  assign out_load      = v_q[NSTAGE-1] & (~out_valid_q | mapped_o.ready);
  assign out_valid_d   = out_load | (out_valid_q & ~mapped_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[NSTAGE-2:0], point_i.valid};
      end
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offsets from the centre
  // ---------------------------------------------------------------------------
  assign dx_d = DW'(point_i.point_x) - DW'(cx_q);
  assign dy_d = DW'(point_i.point_y) - DW'(cy_q);

  // Stages 2-4: squares and cross product of the offsets
  ldpm_mul #(.AW(DW), .BW(DW), .SH(0)) u_mul_dxsq (
    .clk_i(clk_i), .en_i(adv), .a_i(dx_q), .b_i(dx_q), .p_o(dxsq)
  );
  ldpm_mul #(.AW(DW), .BW(DW), .SH(0)) u_mul_dysq (
    .clk_i(clk_i), .en_i(adv), .a_i(dy_q), .b_i(dy_q), .p_o(dysq)
  );
  ldpm_mul #(.AW(DW), .BW(DW), .SH(0)) u_mul_dxdy (
    .clk_i(clk_i), .en_i(adv), .a_i(dx_q), .b_i(dy_q), .p_o(dxdy)
  );

  // Stage 5: squared distance, saturated
  assign sum_d = SUMW'(ldpm_pkg::sat60(SATW'(dxsq) + SATW'(dysq)));

  // Stages 6-8: normalised r^2
  ldpm_mul #(.AW(SUMW), .BW(INVSW), .SH(SH_R2)) u_mul_r2 (
    .clk_i(clk_i), .en_i(adv), .a_i(sum_q), .b_i(inv_s), .p_o(r2)
  );

  // Stages 9-11: r^4; stages 12-14: r^6
  ldpm_mul #(.AW(R2W), .BW(R2W), .SH(FRAC)) u_mul_r4 (
    .clk_i(clk_i), .en_i(adv), .a_i(r2), .b_i(r2), .p_o(r4)
  );
  ldpm_delay #(.WIDTH(R2W), .DEPTH(3)) u_dly_r2_a (
    .clk_i(clk_i), .en_i(adv), .d_i(r2), .q_o(r2_s11)
  );
  ldpm_mul #(.AW(R4W), .BW(R2W), .SH(FRAC)) u_mul_r6 (
    .clk_i(clk_i), .en_i(adv), .a_i(r4), .b_i(r2_s11), .p_o(r6)
  );
  ldpm_delay #(.WIDTH(R2W), .DEPTH(3)) u_dly_r2_b (
    .clk_i(clk_i), .en_i(adv), .d_i(r2_s11), .q_o(r2_s14)
  );
  ldpm_delay #(.WIDTH(R4W), .DEPTH(3)) u_dly_r4 (
    .clk_i(clk_i), .en_i(adv), .d_i(r4), .q_o(r4_s14)
  );

  // Stages 15-17: radial coefficient terms, aligned on one stage
  ldpm_mul #(.AW(COEF_WIDTH), .BW(R2W), .SH(FRAC)) u_mul_k1 (
    .clk_i(clk_i), .en_i(adv), .a_i(k1_q), .b_i(r2_s14), .p_o(t1)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(R4W), .SH(FRAC)) u_mul_k2 (
    .clk_i(clk_i), .en_i(adv), .a_i(k2_q), .b_i(r4_s14), .p_o(t2)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(R6W), .SH(FRAC)) u_mul_k3 (
    .clk_i(clk_i), .en_i(adv), .a_i(k3_q), .b_i(r6), .p_o(t3)
  );

  // Stage 18: pairwise sums; stage 19: radial scale, saturated once
  assign sa_d    = SCALE_ONE + ACCW'(t1);
  assign sb_d    = ACCW'(t2) + ACCW'(t3);
  assign scale_d = VALW'(ldpm_pkg::sat60(SATW'(sa_q + sb_q)));

  // Hold the offsets until the scale is ready
  ldpm_delay #(.WIDTH(2 * DW), .DEPTH(18)) u_dly_d (
    .clk_i(clk_i), .en_i(adv), .d_i({dx_q, dy_q}), .q_o({dx_s19, dy_s19})
  );

  // Stages 20-22: scaled offsets
  ldpm_mul #(.AW(VALW), .BW(DW), .SH(FRAC)) u_mul_xr (
    .clk_i(clk_i), .en_i(adv), .a_i(scale_q), .b_i(dx_s19), .p_o(xr)
  );
  ldpm_mul #(.AW(VALW), .BW(DW), .SH(FRAC)) u_mul_yr (
    .clk_i(clk_i), .en_i(adv), .a_i(scale_q), .b_i(dy_s19), .p_o(yr)
  );

  // ---------------------------------------------------------------------------
  // Tangential branch: runs beside the radial chain and waits for it
  // ---------------------------------------------------------------------------
  ldpm_delay #(.WIDTH(3 * SQW), .DEPTH(4)) u_dly_sq (
    .clk_i(clk_i), .en_i(adv), .d_i({dxsq, dysq, dxdy}),
    .q_o({dxsq_s8, dysq_s8, dxdy_s8})
  );

  // Stages 9-11: the six tangential products, each floored on its own
  ldpm_mul #(.AW(COEF_WIDTH), .BW(SQW), .SH(SH_DXY)) u_mul_ta1 (
    .clk_i(clk_i), .en_i(adv), .a_i(p1_q), .b_i(dxdy_s8), .p_o(ta1)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(R2W), .SH(SH_TR2)) u_mul_ta2 (
    .clk_i(clk_i), .en_i(adv), .a_i(p2_q), .b_i(r2), .p_o(ta2)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(SQW), .SH(SH_DXY)) u_mul_ta3 (
    .clk_i(clk_i), .en_i(adv), .a_i(p2_q), .b_i(dxsq_s8), .p_o(ta3)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(R2W), .SH(SH_TR2)) u_mul_tb1 (
    .clk_i(clk_i), .en_i(adv), .a_i(p1_q), .b_i(r2), .p_o(tb1)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(SQW), .SH(SH_DXY)) u_mul_tb2 (
    .clk_i(clk_i), .en_i(adv), .a_i(p1_q), .b_i(dysq_s8), .p_o(tb2)
  );
  ldpm_mul #(.AW(COEF_WIDTH), .BW(SQW), .SH(SH_DXY)) u_mul_tb3 (
    .clk_i(clk_i), .en_i(adv), .a_i(p2_q), .b_i(dxdy_s8), .p_o(tb3)
  );

  // Stage 12: partial sums; stage 13: full sums, saturated once
  assign txa_d = ACCW'(ta1) + ACCW'(ta2);
  assign tya_d = ACCW'(tb1) + ACCW'(tb2);
  assign tx_d  = VALW'(ldpm_pkg::sat60(SATW'(txa_q + ACCW'(ta3_q))));
  assign ty_d  = VALW'(ldpm_pkg::sat60(SATW'(tya_q + ACCW'(tb3_q))));

  ldpm_delay #(.WIDTH(2 * VALW), .DEPTH(9)) u_dly_t (
    .clk_i(clk_i), .en_i(adv), .d_i({tx_q, ty_q}), .q_o({tx_s22, ty_s22})
  );

  // Stage 23: radial plus tangential; stage 24: add the centre and saturate
  assign xs_d = ACCW'(xr) + ACCW'(tx_s22);
  assign ys_d = ACCW'(yr) + ACCW'(ty_s22);
  assign mx_d = sat_coord(ACCW'(cx_q) + xs_q);
  assign my_d = sat_coord(ACCW'(cy_q) + ys_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      sum_q   <= sum_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      scale_q <= scale_d;
      txa_q   <= txa_d;
      tya_q   <= tya_d;
      ta3_q   <= ta3;
      tb3_q   <= tb3;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
      xs_q    <= xs_d;
      ys_q    <= ys_d;
      mx_q    <= mx_d;
      my_q    <= my_d;
    end
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mapped_x_q <= mx_q;
      mapped_y_q <= my_q;
    end
  end

  assign mapped_o.valid    = out_valid_q;
  assign mapped_o.mapped_x = mapped_x_q;
  assign mapped_o.mapped_y = mapped_y_q;

endmodule

### rtl/core/ldpm_checker.sv
// Port-level checks of the lens distortion point map, bound to the top level.
`include "assert_macros.svh"

module ldpm_checker #(
  parameter int unsigned COORD_WIDTH = ldpm_pkg::COORD_WIDTH_DEF,
  parameter int unsigned DEPTH       = ldpm_pkg::PIPE_STAGES + 1
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [COORD_WIDTH-1:0] mapped_x_i,
  input logic signed [COORD_WIDTH-1:0] mapped_y_i
);

  localparam int unsigned CW = $clog2(DEPTH + 2);

  logic          in_beat, out_beat;
  logic          out_stall;
  logic [2*COORD_WIDTH-1:0] out_data;
  logic [CW-1:0] in_flight_d, in_flight_q;

  assign in_beat   = in_valid_i & in_ready_i;
  assign out_beat  = out_valid_i & out_ready_i;
  assign out_stall = out_valid_i & ~out_ready_i;
  assign out_data  = {mapped_x_i, mapped_y_i};

  always_comb begin
    in_flight_d = in_flight_q;
    if (in_beat && !out_beat) begin
      in_flight_d = in_flight_q + CW'(1);
    end else if (!in_beat && out_beat) begin
      in_flight_d = in_flight_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= '0;
    end else begin
      in_flight_q <= in_flight_d;
    end
  end

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_data))

  // an empty output register never blocks input
  `ASSERT_ALWAYS(a_ready_when_empty, clk_i, rst_ni, out_valid_i || in_ready_i)

  // every result beat belongs to an accepted point
  `ASSERT_ALWAYS(a_no_orphan, clk_i, rst_ni, !out_beat || (in_flight_q != '0))

  // no more points in flight than the pipeline holds
  `ASSERT_ALWAYS(a_bounded, clk_i, rst_ni, in_flight_q <= CW'(DEPTH))

endmodule

bind lens_distortion_point_map ldpm_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .DEPTH      (ldpm_pkg::PIPE_STAGES + 1)
) u_ldpm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (point_i.valid),
  .in_ready_i (point_i.ready),
  .out_valid_i(mapped_o.valid),
  .out_ready_i(mapped_o.ready),
  .mapped_x_i (mapped_o.mapped_x),
  .mapped_y_i (mapped_o.mapped_y)
);
